// ----- rtl/ptqm_pkg.sv -----
package ptqm_pkg;

	localparam int CMD_W  = 3;
	localparam int QID_W  = 4;
	localparam int PID_W  = 5;
	localparam int STAT_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC  = 3'd0,
		CMD_FREE   = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_POP    = 3'd3,
		CMD_REMOVE = 3'd4,
		CMD_PEEK   = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_NONE    = 3'd1,
		STAT_MAXQ    = 3'd2,
		STAT_NOSLOT  = 3'd3,
		STAT_CORRUPT = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_DISP,
		S_ALLOC_RD,
		S_ALLOC_WB,
		S_FREE_CLR,
		S_TAIL_RD,
		S_TAIL_CHK,
		S_INS_CNT,
		S_INS_CNTCHK,
		S_INS_SRD,
		S_INS_SCHK,
		S_INS_TRD,
		S_INS_TCHK,
		S_INS_TW,
		S_INS_FIN,
		S_WALK_RD,
		S_WALK_CHK,
		S_CUR_RD,
		S_CUR_CHK,
		S_REM_CLR,
		S_REM_CDEC
	} state_t;

endpackage

// ----- rtl/ptqm_ram.sv -----
module ptqm_ram #(
	parameter int W  = 8,
	parameter int D  = 32,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/process_table_queue_manager.sv -----
// Process table queue manager: a free list and circular FIFO queues of process
// entries, kept as linked lists in a link memory of NUM_PROCS*LINKS_PER_PROC slots.
// Input channel s_*: one command per transfer (allocate, free, insert, pop head,
// remove given, peek head). Output channel m_*: exactly one result per command,
// the entry concerned and a status code.
// A command is taken only while the block is idle and the result register is
// empty; the block then works alone on it.
// Free clears every slot of the entry, insert searches its slots for a free one,
// and pop and remove walk the queue, at most NUM_PROCS*LINKS_PER_PROC links.
// After reset a clearing pass over max(NUM_PROCS*LINKS_PER_PROC, NUM_QUEUES)
// addresses (256 at the defaults) writes the free chain, zero counts and empty
// queues; s_tready stays low meanwhile.
// A stalled receiver holds the result in the output register; the next command
// is taken once that result has been transferred.
module process_table_queue_manager #(
	parameter int NUM_PROCS      = 32,
	parameter int LINKS_PER_PROC = 8,
	parameter int NUM_QUEUES     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // command[2:0], queue_id[6:3], proc_id[11:7], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // result_proc[4:0], status[7:5]
);

	localparam int PW    = $clog2(NUM_PROCS);
	localparam int SW    = (LINKS_PER_PROC > 1) ? $clog2(LINKS_PER_PROC) : 1;
	localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int LD    = NUM_PROCS * LINKS_PER_PROC;
	localparam int AW    = $clog2(LD);
	localparam int CW    = $clog2(LINKS_PER_PROC + 1);
	localparam int SWEEP = (LD > NUM_QUEUES) ? LD : NUM_QUEUES;
	localparam int IW    = $clog2(SWEEP);
	localparam int RW    = 1 + SW + PW;

	ptqm_pkg::state_t  state_q, state_d;
	ptqm_pkg::cmd_t    cmd_q;
	logic [ptqm_pkg::QID_W-1:0] q_q;
	logic [ptqm_pkg::PID_W-1:0] p_q;
	logic [PW-1:0] free_head_q;
	logic          free_valid_q;
	logic [PW-1:0] t_q, pe_q, ce_q;
	logic [SW-1:0] ts_q, ps_q, cs_q, s_q;
	logic          busy_q;
	logic [AW-1:0] n_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] i_q;
	logic [PW-1:0] ie_q;
	logic [SW-1:0] is_q;
	logic          ov_q;
	logic [PW-1:0] ores_q;
	ptqm_pkg::status_t ost_q;

	logic          lwe, cwe, twe;
	logic [AW-1:0] lwa, lra;
	logic [RW-1:0] lwd, lrd, twd, trd;
	logic [PW-1:0] cwa, cra;
	logic [CW-1:0] cwd, crd;
	logic [QW-1:0] twa, tra;

	logic              fin_v;
	ptqm_pkg::status_t fin_st;
	logic [PW-1:0]     fin_res;

	function automatic logic [AW-1:0] la(input logic [PW-1:0] e, input logic [SW-1:0] s);
		return AW'(AW'(e) * AW'(LINKS_PER_PROC) + AW'(s));
	endfunction

	ptqm_ram #(.W(RW), .D(LD), .AW(AW)) u_link (
		.clk(clk), .we(lwe), .waddr(lwa), .wdata(lwd), .raddr(lra), .rdata(lrd)
	);
	ptqm_ram #(.W(CW), .D(NUM_PROCS), .AW(PW)) u_count (
		.clk(clk), .we(cwe), .waddr(cwa), .wdata(cwd), .raddr(cra), .rdata(crd)
	);
	ptqm_ram #(.W(RW), .D(NUM_QUEUES), .AW(QW)) u_tail (
		.clk(clk), .we(twe), .waddr(twa), .wdata(twd), .raddr(tra), .rdata(trd)
	);

	logic          l_used, t_busy;
	logic [SW-1:0] l_slot, s_last;
	logic [PW-1:0] l_next, p_ent;
	logic          p_ok, q_ok, q_cmd_ok, match, at_tail, cur_tail, prev_tail;
	logic          n_last, s_at_last, init_last;

	assign l_used    = lrd[RW-1];
	assign l_slot    = lrd[PW +: SW];
	assign l_next    = lrd[PW-1:0];
	assign t_busy    = trd[RW-1];
	assign p_ent     = PW'(p_q);
	assign s_last    = SW'(LINKS_PER_PROC - 1);
	assign s_at_last = (s_q == s_last);
	assign p_ok      = (int'(p_q) < NUM_PROCS);
	assign q_ok      = (int'(q_q) < NUM_QUEUES);
	assign q_cmd_ok  = q_ok && (p_ok || cmd_q == ptqm_pkg::CMD_POP
		|| cmd_q == ptqm_pkg::CMD_PEEK);
	assign match     = (cmd_q == ptqm_pkg::CMD_POP) || (int'(l_next) == int'(p_q));
	assign at_tail   = (l_next == t_q) && (l_slot == ts_q);
	assign cur_tail  = (ce_q == t_q) && (cs_q == ts_q);
	assign prev_tail = (pe_q == t_q) && (ps_q == ts_q);
	assign n_last    = (n_q == AW'(LD - 1));
	assign init_last = (i_q == IW'(SWEEP - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptqm_pkg::S_INIT:       if (init_last) state_d = ptqm_pkg::S_IDLE;
			ptqm_pkg::S_IDLE:       if (s_tvalid && s_tready) state_d = ptqm_pkg::S_DISP;
			ptqm_pkg::S_DISP: begin
				unique case (cmd_q)
					ptqm_pkg::CMD_ALLOC:
						state_d = free_valid_q ? ptqm_pkg::S_ALLOC_RD : ptqm_pkg::S_IDLE;
					ptqm_pkg::CMD_FREE:
						state_d = p_ok ? ptqm_pkg::S_FREE_CLR : ptqm_pkg::S_IDLE;
					ptqm_pkg::CMD_INSERT, ptqm_pkg::CMD_POP,
					ptqm_pkg::CMD_REMOVE, ptqm_pkg::CMD_PEEK:
						state_d = q_cmd_ok ? ptqm_pkg::S_TAIL_RD : ptqm_pkg::S_IDLE;
					default: state_d = ptqm_pkg::S_IDLE;
				endcase
			end
			ptqm_pkg::S_ALLOC_RD:   state_d = ptqm_pkg::S_ALLOC_WB;
			ptqm_pkg::S_ALLOC_WB:   state_d = ptqm_pkg::S_IDLE;
			ptqm_pkg::S_FREE_CLR:   if (s_at_last) state_d = ptqm_pkg::S_IDLE;
			ptqm_pkg::S_TAIL_RD:    state_d = ptqm_pkg::S_TAIL_CHK;
			ptqm_pkg::S_TAIL_CHK: begin
				priority if (cmd_q == ptqm_pkg::CMD_INSERT) state_d = ptqm_pkg::S_INS_CNT;
				else if (!t_busy) state_d = ptqm_pkg::S_IDLE;
				else state_d = ptqm_pkg::S_WALK_RD;
			end
			ptqm_pkg::S_INS_CNT:    state_d = ptqm_pkg::S_INS_CNTCHK;
			ptqm_pkg::S_INS_CNTCHK:
				state_d = (crd >= CW'(LINKS_PER_PROC)) ? ptqm_pkg::S_IDLE : ptqm_pkg::S_INS_SRD;
			ptqm_pkg::S_INS_SRD:    state_d = ptqm_pkg::S_INS_SCHK;
			ptqm_pkg::S_INS_SCHK: begin
				priority if (!l_used) state_d = busy_q ? ptqm_pkg::S_INS_TRD : ptqm_pkg::S_INS_FIN;
				else if (s_at_last) state_d = ptqm_pkg::S_IDLE;
				else state_d = ptqm_pkg::S_INS_SRD;
			end
			ptqm_pkg::S_INS_TRD:    state_d = ptqm_pkg::S_INS_TCHK;
			ptqm_pkg::S_INS_TCHK:   state_d = l_used ? ptqm_pkg::S_INS_TW : ptqm_pkg::S_IDLE;
			ptqm_pkg::S_INS_TW:     state_d = ptqm_pkg::S_INS_FIN;
			ptqm_pkg::S_INS_FIN:    state_d = ptqm_pkg::S_IDLE;
			ptqm_pkg::S_WALK_RD:    state_d = ptqm_pkg::S_WALK_CHK;
			ptqm_pkg::S_WALK_CHK: begin
				priority if (!l_used) state_d = ptqm_pkg::S_IDLE;
				else if (cmd_q == ptqm_pkg::CMD_PEEK) state_d = ptqm_pkg::S_IDLE;
				else if (match) state_d = ptqm_pkg::S_CUR_RD;
				else if (at_tail || n_last) state_d = ptqm_pkg::S_IDLE;
				else state_d = ptqm_pkg::S_WALK_RD;
			end
			ptqm_pkg::S_CUR_RD:     state_d = ptqm_pkg::S_CUR_CHK;
			ptqm_pkg::S_CUR_CHK:    state_d = l_used ? ptqm_pkg::S_REM_CLR : ptqm_pkg::S_IDLE;
			ptqm_pkg::S_REM_CLR:    state_d = ptqm_pkg::S_REM_CDEC;
			ptqm_pkg::S_REM_CDEC:   state_d = ptqm_pkg::S_IDLE;
			default:                state_d = ptqm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		lwe = 1'b0; lwa = '0; lwd = '0; lra = '0;
		cwe = 1'b0; cwa = '0; cwd = '0; cra = '0;
		twe = 1'b0; twa = '0; twd = '0; tra = '0;
		fin_v = 1'b0; fin_st = ptqm_pkg::STAT_NONE; fin_res = '0;
		unique case (state_q)
			ptqm_pkg::S_INIT: begin
				lwe = (int'(i_q) < LD);
				lwa = AW'(i_q);
				if (is_q == '0 && ie_q != PW'(NUM_PROCS - 1)) begin
					lwd = {1'b1, SW'(0), PW'(ie_q + 1'b1)};
				end
				cwe = (int'(i_q) < NUM_PROCS);
				cwa = PW'(i_q);
				twe = (int'(i_q) < NUM_QUEUES);
				twa = QW'(i_q);
			end
			ptqm_pkg::S_DISP: begin
				unique case (cmd_q)
					ptqm_pkg::CMD_ALLOC:  fin_v = !free_valid_q;
					ptqm_pkg::CMD_FREE:   fin_v = !p_ok;
					ptqm_pkg::CMD_INSERT, ptqm_pkg::CMD_POP,
					ptqm_pkg::CMD_REMOVE, ptqm_pkg::CMD_PEEK: fin_v = !q_cmd_ok;
					default:              fin_v = 1'b1;
				endcase
			end
			ptqm_pkg::S_ALLOC_RD: lra = la(free_head_q, '0);
			ptqm_pkg::S_ALLOC_WB: begin
				lwe = 1'b1;
				lwa = la(free_head_q, '0);
				fin_v = 1'b1; fin_st = ptqm_pkg::STAT_OK; fin_res = free_head_q;
			end
			ptqm_pkg::S_FREE_CLR: begin
				lwe = 1'b1;
				lwa = la(p_ent, s_q);
				if (s_q == '0 && free_valid_q) lwd = {1'b1, SW'(0), free_head_q};
				cwe = 1'b1;
				cwa = p_ent;
				if (s_at_last) begin
					fin_v = 1'b1; fin_st = ptqm_pkg::STAT_OK; fin_res = p_ent;
				end
			end
			ptqm_pkg::S_TAIL_RD: tra = QW'(q_q);
			ptqm_pkg::S_TAIL_CHK: fin_v = (cmd_q != ptqm_pkg::CMD_INSERT) && !t_busy;
			ptqm_pkg::S_INS_CNT: cra = p_ent;
			ptqm_pkg::S_INS_CNTCHK: begin
				fin_v = (crd >= CW'(LINKS_PER_PROC));
				fin_st = ptqm_pkg::STAT_MAXQ;
			end
			ptqm_pkg::S_INS_SRD: lra = la(p_ent, s_q);
			ptqm_pkg::S_INS_SCHK: begin
				if (!l_used && !busy_q) begin
					lwe = 1'b1;
					lwa = la(p_ent, s_q);
					lwd = {1'b1, s_q, p_ent};
				end
				fin_v = l_used && s_at_last;
				fin_st = ptqm_pkg::STAT_NOSLOT;
			end
			ptqm_pkg::S_INS_TRD: lra = la(t_q, ts_q);
			ptqm_pkg::S_INS_TCHK: begin
				lwe = l_used;
				lwa = la(p_ent, s_q);
				lwd = {1'b1, l_slot, l_next};
				fin_v = !l_used;
				fin_st = ptqm_pkg::STAT_CORRUPT;
			end
			ptqm_pkg::S_INS_TW: begin
				lwe = 1'b1;
				lwa = la(t_q, ts_q);
				lwd = {1'b1, s_q, p_ent};
			end
			ptqm_pkg::S_INS_FIN: begin
				cwe = 1'b1; cwa = p_ent; cwd = cnt_q + 1'b1;
				twe = 1'b1; twa = QW'(q_q); twd = {1'b1, s_q, p_ent};
				fin_v = 1'b1; fin_st = ptqm_pkg::STAT_OK; fin_res = p_ent;
			end
			ptqm_pkg::S_WALK_RD: lra = la(pe_q, ps_q);
			ptqm_pkg::S_WALK_CHK: begin
				priority if (!l_used) begin
					fin_v = 1'b1; fin_st = ptqm_pkg::STAT_CORRUPT;
				end else if (cmd_q == ptqm_pkg::CMD_PEEK) begin
					fin_v = 1'b1; fin_st = ptqm_pkg::STAT_OK; fin_res = l_next;
				end else if (match) begin
					fin_v = 1'b0;
				end else if (at_tail) begin
					fin_v = 1'b1; fin_st = ptqm_pkg::STAT_NONE;
				end else if (n_last) begin
					fin_v = 1'b1; fin_st = ptqm_pkg::STAT_CORRUPT;
				end else begin
					fin_v = 1'b0;
				end
			end
			ptqm_pkg::S_CUR_RD: lra = la(ce_q, cs_q);
			ptqm_pkg::S_CUR_CHK: begin
				if (l_used) begin
					if (cur_tail && prev_tail) begin
						twe = 1'b1; twa = QW'(q_q); twd = {1'b0, ts_q, t_q};
					end else begin
						lwe = 1'b1;
						lwa = la(pe_q, ps_q);
						lwd = {1'b1, l_slot, l_next};
						twe = cur_tail; twa = QW'(q_q); twd = {1'b1, ps_q, pe_q};
					end
				end
				fin_v = !l_used;
				fin_st = ptqm_pkg::STAT_CORRUPT;
			end
			ptqm_pkg::S_REM_CLR: begin
				lwe = 1'b1;
				lwa = la(ce_q, cs_q);
				cra = ce_q;
			end
			ptqm_pkg::S_REM_CDEC: begin
				cwe = 1'b1; cwa = ce_q;
				cwd = (crd != '0) ? crd - 1'b1 : '0;
				fin_v = 1'b1; fin_st = ptqm_pkg::STAT_OK; fin_res = ce_q;
			end
			default: fin_v = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ptqm_pkg::S_INIT;
			free_head_q  <= '0;
			free_valid_q <= 1'b1;
			i_q          <= '0;
			ie_q         <= '0;
			is_q         <= '0;
			ov_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ptqm_pkg::S_INIT) begin
				i_q <= i_q + 1'b1;
				if (is_q == s_last) begin
					is_q <= '0;
					ie_q <= ie_q + 1'b1;
				end else begin
					is_q <= is_q + 1'b1;
				end
			end
			if (state_q == ptqm_pkg::S_ALLOC_WB) begin
				if (l_used) free_head_q <= l_next;
				else free_valid_q <= 1'b0;
			end
			if (state_q == ptqm_pkg::S_FREE_CLR && s_at_last) begin
				free_head_q  <= p_ent;
				free_valid_q <= 1'b1;
			end
			if (fin_v) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= ptqm_pkg::cmd_t'(s_tdata[2:0]);
			q_q   <= s_tdata[6:3];
			p_q   <= s_tdata[11:7];
		end
		if (state_q == ptqm_pkg::S_DISP) s_q <= '0;
		if (state_q == ptqm_pkg::S_FREE_CLR) s_q <= s_q + 1'b1;
		if (state_q == ptqm_pkg::S_INS_SCHK && l_used) s_q <= s_q + 1'b1;
		if (state_q == ptqm_pkg::S_INS_CNTCHK) cnt_q <= crd;
		if (state_q == ptqm_pkg::S_TAIL_CHK) begin
			t_q    <= trd[PW-1:0];
			ts_q   <= trd[PW +: SW];
			busy_q <= t_busy;
			pe_q   <= trd[PW-1:0];
			ps_q   <= trd[PW +: SW];
			n_q    <= '0;
		end
		if (state_q == ptqm_pkg::S_WALK_CHK) begin
			ce_q <= l_next;
			cs_q <= l_slot;
			if (state_d == ptqm_pkg::S_WALK_RD) begin
				pe_q <= l_next;
				ps_q <= l_slot;
				n_q  <= n_q + 1'b1;
			end
		end
		if (fin_v) begin
			ores_q <= fin_res;
			ost_q  <= fin_st;
		end
	end

	assign s_tready = (state_q == ptqm_pkg::S_IDLE) && !ov_q;
	assign m_tvalid = ov_q;
	assign m_tdata  = {ost_q, ptqm_pkg::PID_W'(ores_q)};

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a command was in work");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ost_q != ptqm_pkg::STAT_OK) |-> (ores_q == '0))
		else $error("nonzero entry with error status");

	a_free_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(free_valid_q) |-> ($past(state_q) == ptqm_pkg::S_ALLOC_WB))
		else $error("free list emptied outside allocate");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) != ptqm_pkg::S_IDLE
			&& $past(state_q) != ptqm_pkg::S_INIT))
		else $error("result without a command");

endmodule

// ----- tb/process_table_queue_manager_test.sv -----
`timescale 1ns / 1ps

module process_table_queue_manager_test;

	localparam int NPROC = 32;
	localparam int NLINK = 8;
	localparam int NQUEUE = 16;
	localparam int WALK_MAX = NPROC * NLINK;
	localparam int N_RANDOM = 1800;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;
	localparam int N_MSG = 10;
	localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [4:0] proc_id;
		logic [3:0] queue_id;
		logic [2:0] command;
	} command_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] proc_id;
	} answer_t;

	typedef struct {
		logic [2:0] command;
		logic [3:0] queue_id;
		logic [4:0] proc_id;
		bit         fixed;
		logic [4:0] want_proc;
		logic [2:0] want_status;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;

	bit         pt_free_valid;
	logic [4:0] pt_free_head;
	logic [4:0] pt_next [NPROC][NLINK];
	logic [2:0] pt_slot [NPROC][NLINK];
	bit         pt_used [NPROC][NLINK];
	int         pt_count [NPROC];
	logic [4:0] pt_tail_e [NQUEUE];
	logic [2:0] pt_tail_s [NQUEUE];
	bit         pt_busy [NQUEUE];

	answer_t pending_answers[$];
	int      mismatches;
	int      stall_cycles;
	bit      stim_done;
	bit      hold_rx;
	row_t    dir_rows[$];

	process_table_queue_manager dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic table_reset();
		for (int e = 0; e < NPROC; e++) begin
			pt_count[e] = 0;
			for (int s = 0; s < NLINK; s++) begin
				pt_next[e][s] = '0;
				pt_slot[e][s] = '0;
				pt_used[e][s] = 1'b0;
			end
			if (e + 1 < NPROC) begin
				pt_next[e][0] = 5'(e + 1);
				pt_used[e][0] = 1'b1;
			end
		end
		for (int q = 0; q < NQUEUE; q++) begin
			pt_tail_e[q] = '0;
			pt_tail_s[q] = '0;
			pt_busy[q] = 1'b0;
		end
		pt_free_head = '0;
		pt_free_valid = 1'b1;
	endtask

	function automatic void clear_slot(int e, int s);
		pt_next[e][s] = '0;
		pt_slot[e][s] = '0;
		pt_used[e][s] = 1'b0;
	endfunction

	function automatic answer_t table_apply(command_t c);
		int      cmd, q, p, t, ts, s, pe, ps, ce, cs;
		answer_t a;
		cmd = c.command;
		q = c.queue_id;
		p = c.proc_id;
		a.status = ptqm_pkg::STAT_NONE;
		a.proc_id = '0;
		if (cmd == ptqm_pkg::CMD_ALLOC) begin
			if (pt_free_valid) begin
				a.proc_id = pt_free_head;
				if (pt_used[a.proc_id][0]) pt_free_head = pt_next[a.proc_id][0];
				else pt_free_valid = 1'b0;
				clear_slot(a.proc_id, 0);
				a.status = ptqm_pkg::STAT_OK;
			end
		end else if (cmd == ptqm_pkg::CMD_FREE) begin
			for (s = 0; s < NLINK; s++) clear_slot(p, s);
			pt_count[p] = 0;
			if (pt_free_valid) begin
				pt_next[p][0] = pt_free_head;
				pt_used[p][0] = 1'b1;
			end
			pt_free_head = 5'(p);
			pt_free_valid = 1'b1;
			a.proc_id = 5'(p);
			a.status = ptqm_pkg::STAT_OK;
		end else if (cmd >= ptqm_pkg::CMD_INSERT && cmd <= ptqm_pkg::CMD_PEEK) begin
			t = pt_tail_e[q];
			ts = pt_tail_s[q];
			if (cmd == ptqm_pkg::CMD_INSERT) begin
				for (s = 0; s < NLINK; s++) if (!pt_used[p][s]) break;
				if (pt_count[p] >= NLINK) a.status = ptqm_pkg::STAT_MAXQ;
				else if (s == NLINK) a.status = ptqm_pkg::STAT_NOSLOT;
				else if (pt_busy[q] && !pt_used[t][ts]) a.status = ptqm_pkg::STAT_CORRUPT;
				else begin
					if (pt_busy[q]) begin
						pt_next[p][s] = pt_next[t][ts];
						pt_slot[p][s] = pt_slot[t][ts];
						pt_next[t][ts] = 5'(p);
						pt_slot[t][ts] = 3'(s);
					end else begin
						pt_next[p][s] = 5'(p);
						pt_slot[p][s] = 3'(s);
					end
					pt_used[p][s] = 1'b1;
					pt_count[p]++;
					pt_tail_e[q] = 5'(p);
					pt_tail_s[q] = 3'(s);
					pt_busy[q] = 1'b1;
					a.proc_id = 5'(p);
					a.status = ptqm_pkg::STAT_OK;
				end
			end else if (!pt_busy[q]) begin
				a.status = ptqm_pkg::STAT_NONE;
			end else if (!pt_used[t][ts]) begin
				a.status = ptqm_pkg::STAT_CORRUPT;
			end else if (cmd == ptqm_pkg::CMD_PEEK) begin
				a.proc_id = pt_next[t][ts];
				a.status = ptqm_pkg::STAT_OK;
			end else begin
				pe = t;
				ps = ts;
				a.status = ptqm_pkg::STAT_CORRUPT;
				for (int n = 0; n < WALK_MAX; n++) begin
					if (!pt_used[pe][ps]) break;
					ce = pt_next[pe][ps];
					cs = pt_slot[pe][ps];
					if (cmd == ptqm_pkg::CMD_POP || ce == p) begin
						if (!pt_used[ce][cs]) break;
						if (ce == t && cs == ts && pe == t && ps == ts) begin
							pt_busy[q] = 1'b0;
						end else begin
							pt_next[pe][ps] = pt_next[ce][cs];
							pt_slot[pe][ps] = pt_slot[ce][cs];
							if (ce == t && cs == ts) begin
								pt_tail_e[q] = 5'(pe);
								pt_tail_s[q] = 3'(ps);
							end
						end
						clear_slot(ce, cs);
						if (pt_count[ce] > 0) pt_count[ce]--;
						a.proc_id = 5'(ce);
						a.status = ptqm_pkg::STAT_OK;
						break;
					end
					if (ce == t && cs == ts) begin
						a.status = ptqm_pkg::STAT_NONE;
						break;
					end
					pe = ce;
					ps = cs;
				end
			end
		end
		if (a.status != ptqm_pkg::STAT_OK) a.proc_id = '0;
		return a;
	endfunction

	task automatic send_command(command_t c, bit fixed, answer_t want);
		answer_t a;
		int      idle;
		idle = $urandom_range(0, 9);
		if (idle > 0) begin
			s_tvalid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		s_tdata <= {4'd0, c};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		a = table_apply(c);
		pending_answers.push_back(fixed ? want : a);
		@(negedge clk);
	endtask

	function automatic command_t random_command();
		command_t c;
		int r;
		c.queue_id = 4'($urandom_range(0, 3));
		c.proc_id = 5'($urandom_range(0, 7));
		r = $urandom_range(0, 99);
		if (r < 15) c.command = ptqm_pkg::CMD_ALLOC;
		else if (r < 22) c.command = ptqm_pkg::CMD_FREE;
		else if (r < 55) c.command = ptqm_pkg::CMD_INSERT;
		else if (r < 72) c.command = ptqm_pkg::CMD_POP;
		else if (r < 87) c.command = ptqm_pkg::CMD_REMOVE;
		else if (r < 95) c.command = ptqm_pkg::CMD_PEEK;
		else c.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		if ($urandom_range(0, 4) == 0) begin
			c.queue_id = 4'($urandom);
			c.proc_id = 5'($urandom);
		end
		return c;
	endfunction

	task automatic add_row(logic [2:0] cmd, int q, int p, bit fixed, int wp, int ws);
		row_t r;
		r.command = cmd;
		r.queue_id = 4'(q);
		r.proc_id = 5'(p);
		r.fixed = fixed;
		r.want_proc = 5'(wp);
		r.want_status = 3'(ws);
		dir_rows.push_back(r);
	endtask

	initial begin
		command_t c;
		answer_t  w;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		stim_done = 1'b0;
		table_reset();
		add_row(ptqm_pkg::CMD_PEEK, 0, 0, 1, 0, ptqm_pkg::STAT_NONE);
		add_row(ptqm_pkg::CMD_POP, 15, 0, 1, 0, ptqm_pkg::STAT_NONE);
		add_row(ptqm_pkg::CMD_REMOVE, 0, 31, 1, 0, ptqm_pkg::STAT_NONE);
		add_row(CMD_UNUSED_LO, 0, 0, 1, 0, ptqm_pkg::STAT_NONE);
		add_row(CMD_UNUSED_HI, 15, 31, 1, 0, ptqm_pkg::STAT_NONE);
		add_row(ptqm_pkg::CMD_ALLOC, 0, 0, 1, 0, ptqm_pkg::STAT_OK);
		add_row(ptqm_pkg::CMD_ALLOC, 0, 0, 1, 1, ptqm_pkg::STAT_OK);
		add_row(ptqm_pkg::CMD_INSERT, 0, 0, 1, 0, ptqm_pkg::STAT_OK);
		add_row(ptqm_pkg::CMD_INSERT, 0, 1, 1, 1, ptqm_pkg::STAT_OK);
		add_row(ptqm_pkg::CMD_INSERT, 0, 0, 1, 0, ptqm_pkg::STAT_OK);
		add_row(ptqm_pkg::CMD_INSERT, 15, 31, 0, 0, 0);
		add_row(ptqm_pkg::CMD_PEEK, 0, 0, 1, 0, ptqm_pkg::STAT_OK);
		add_row(ptqm_pkg::CMD_REMOVE, 0, 0, 0, 0, 0);
		add_row(ptqm_pkg::CMD_REMOVE, 0, 5, 1, 0, ptqm_pkg::STAT_NONE);
		add_row(ptqm_pkg::CMD_POP, 0, 0, 0, 0, 0);
		add_row(ptqm_pkg::CMD_POP, 0, 0, 0, 0, 0);
		add_row(ptqm_pkg::CMD_POP, 0, 0, 1, 0, ptqm_pkg::STAT_NONE);
		for (int i = 0; i < 9; i++) add_row(ptqm_pkg::CMD_INSERT, i, 2, 0, 0, 0);
		add_row(ptqm_pkg::CMD_FREE, 0, 2, 1, 2, ptqm_pkg::STAT_OK);
		add_row(ptqm_pkg::CMD_FREE, 0, 31, 1, 31, ptqm_pkg::STAT_OK);
		add_row(ptqm_pkg::CMD_PEEK, 15, 0, 0, 0, 0);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (dir_rows[i]) begin
			c.command = dir_rows[i].command;
			c.queue_id = dir_rows[i].queue_id;
			c.proc_id = dir_rows[i].proc_id;
			w.proc_id = dir_rows[i].want_proc;
			w.status = dir_rows[i].want_status;
			send_command(c, dir_rows[i].fixed, w);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			c = random_command();
			send_command(c, 1'b0, w);
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		hold_rx = 1'b0;
		wait (stim_done == 1'b0 && arst_n);
		repeat (2000) @(negedge clk);
		hold_rx = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_rx = 1'b0;
	end

	initial begin
		int rx_wait;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			rx_wait = $urandom_range(0, 9);
			if (rx_wait > 0 || hold_rx) begin
				m_tready <= 1'b0;
				repeat (rx_wait) @(negedge clk);
				while (hold_rx) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		answer_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= N_MSG) $display("unexpected transfer %h", got);
			end else begin
				want = pending_answers.pop_front();
				if (got.proc_id !== want.proc_id || got.status !== want.status) begin
					mismatches++;
					if (mismatches <= N_MSG)
						$display("mismatch: proc exp %0d got %0d, status exp %0d got %0d",
							want.proc_id, got.proc_id, want.status, got.status);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		stall_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
			if (stim_done && pending_answers.size() == 0) begin
				repeat (600) @(posedge clk);
				if (mismatches == 0 && pending_answers.size() == 0) $display("*** PASSED ***");
				else $display("*** FAILED ***");
				$finish;
			end
		end
	end

endmodule

// ----- files.f -----
rtl/ptqm_pkg.sv
rtl/ptqm_ram.sv
rtl/process_table_queue_manager.sv
tb/process_table_queue_manager_test.sv
